/* rtl/fan_triangulate_edge_extract_defines.svh */
// Assertion macros used by the port-level checker (fte_checker) of the fan triangulation block.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef FAN_TRIANGULATE_EDGE_EXTRACT_DEFINES_SVH
`define FAN_TRIANGULATE_EDGE_EXTRACT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fte_pkg.sv */
// Shared types and constants for the fan triangulation and edge extraction block.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package fte_pkg;

	localparam int FIELD_W        = 24;
	localparam int INDEX_BITS_DEF = 24;
	localparam int EDGE_SLOTS_DEF = 1024;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN1,
		S_SCAN2,
		S_EMIT_TRI,
		S_EMIT_E1,
		S_EMIT_E2,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		OUT_TRI,
		OUT_E1,
		OUT_E2
	} out_sel_t;

	typedef struct packed {
		logic     accept;
		logic     scan_start;
		logic     scan_run;
		logic     sel_close;
		logic     commit;
		logic     load;
		out_sel_t out_sel;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] seen;
		logic       last;
		logic       scan_done;
		logic       emit1;
		logic       emit2;
		logic       out_free;
	} status_t;

endpackage

`default_nettype wire

/* rtl/fte_datapath.sv */
// Datapath: face registers, edge memory with linear scan, fill count, output register.
// Depends on fte_pkg; driven by fte_ctrl through cmd_t and reports through status_t.
`default_nettype none

module fte_datapath #(
	parameter int INDEX_BITS = fte_pkg::INDEX_BITS_DEF,
	parameter int EDGE_SLOTS = fte_pkg::EDGE_SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [fte_pkg::FIELD_W-1:0] vertex_id,
	input  wire logic                        mesh_start,
	input  wire logic                        face_end,
	input  wire fte_pkg::cmd_t               cmd,
	output fte_pkg::status_t                 status,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic                             kind,
	output logic [fte_pkg::FIELD_W-1:0]      corner_a,
	output logic [fte_pkg::FIELD_W-1:0]      corner_b,
	output logic [fte_pkg::FIELD_W-1:0]      corner_c,
	output logic                             edge_overflow,
	output logic                             last_result
);

	localparam int OW = fte_pkg::FIELD_W;
	localparam int VW = (INDEX_BITS < OW) ? INDEX_BITS : OW;
	localparam int PW = 2 * VW;
	localparam int AW = $clog2(EDGE_SLOTS);
	localparam int CW = $clog2(EDGE_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(EDGE_SLOTS);

	logic [VW-1:0] first_q, prev_q, cur_v_q;
	logic [1:0]    seen_q, cur_seen_q;
	logic          cur_last_q;
	logic [CW-1:0] fill_q, scan_q;
	logic          rd_pend_q;
	logic [PW-1:0] rd_q;
	logic          emit1_q, emit2_q, ovf1_q, ovf2_q;
	logic [PW-1:0] mem [EDGE_SLOTS];

	logic          out_valid_q, kind_q, ovf_q, last_q;
	logic [OW-1:0] a_q, b_q, c_q;

	logic [VW-1:0] v_in;
	logic [1:0]    seen_eff;
	logic [VW-1:0] e1_lo, e1_hi, e2_lo, e2_hi;
	logic [PW-1:0] tgt;
	logic          hit, has_room, more, wr_en, rd_en, out_free;

	logic          n_kind, n_ovf, n_last;
	logic [OW-1:0] n_a, n_b, n_c;

	assign v_in     = vertex_id[VW-1:0];
	assign seen_eff = mesh_start ? 2'd0 : seen_q;

	assign e1_lo = (prev_q < cur_v_q) ? prev_q : cur_v_q;
	assign e1_hi = (prev_q < cur_v_q) ? cur_v_q : prev_q;
	assign e2_lo = (cur_v_q < first_q) ? cur_v_q : first_q;
	assign e2_hi = (cur_v_q < first_q) ? first_q : cur_v_q;
	assign tgt   = cmd.sel_close ? {e2_lo, e2_hi} : {e1_lo, e1_hi};

	assign hit      = rd_pend_q && (rd_q == tgt);
	assign more     = scan_q < fill_q;
	assign has_room = fill_q < SLOTS_C;
	assign wr_en    = cmd.commit && !hit && has_room;
	assign rd_en    = cmd.scan_run && !cmd.scan_start && more;
	assign out_free = !out_valid_q || out_ready;

	assign status.seen      = cur_seen_q;
	assign status.last      = cur_last_q;
	assign status.scan_done = hit || (!rd_pend_q && !more);
	assign status.emit1     = emit1_q;
	assign status.emit2     = emit2_q;
	assign status.out_free  = out_free;

	// face tracking and per-corner item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= '0;
			prev_q     <= '0;
			seen_q     <= 2'd0;
			cur_v_q    <= '0;
			cur_seen_q <= 2'd0;
			cur_last_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cur_v_q    <= v_in;
				cur_seen_q <= seen_eff;
				cur_last_q <= face_end;
				if (seen_eff == 2'd0) begin
					first_q <= v_in;
					prev_q  <= v_in;
				end
			end
			if (cmd.finish) begin
				prev_q <= cur_v_q;
				if (cur_last_q)
					seen_q <= 2'd0;
				else if (cur_seen_q == 2'd2)
					seen_q <= 2'd2;
				else
					seen_q <= cur_seen_q + 2'd1;
			end
		end
	end

	// fill count, scan pointer and lookup outcomes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			scan_q    <= '0;
			rd_pend_q <= 1'b0;
			emit1_q   <= 1'b0;
			emit2_q   <= 1'b0;
			ovf1_q    <= 1'b0;
			ovf2_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				emit1_q <= 1'b0;
				emit2_q <= 1'b0;
				if (mesh_start)
					fill_q <= '0;
			end
			if (wr_en)
				fill_q <= fill_q + CW'(1);
			if (cmd.commit) begin
				if (cmd.sel_close) begin
					emit2_q <= !hit;
					ovf2_q  <= !has_room;
				end else begin
					emit1_q <= !hit;
					ovf1_q  <= !has_room;
				end
			end
			if (cmd.scan_start) begin
				scan_q    <= '0;
				rd_pend_q <= 1'b0;
			end else if (cmd.scan_run) begin
				rd_pend_q <= more;
				if (more)
					scan_q <= scan_q + CW'(1);
			end
		end
	end

	// edge memory: store at the fill position, read one entry a cycle during a scan
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[fill_q[AW-1:0]] <= tgt;
		if (rd_en)
			rd_q <= mem[scan_q[AW-1:0]];
	end

	always_comb begin
		n_kind = 1'b0;
		n_a    = '0;
		n_b    = '0;
		n_c    = '0;
		n_ovf  = 1'b0;
		n_last = 1'b1;
		case (cmd.out_sel)
			fte_pkg::OUT_TRI: begin
				n_a    = OW'(first_q);
				n_b    = OW'(prev_q);
				n_c    = OW'(cur_v_q);
				n_last = !emit1_q && !emit2_q;
			end
			fte_pkg::OUT_E1: begin
				n_kind = 1'b1;
				n_a    = OW'(e1_lo);
				n_b    = OW'(e1_hi);
				n_ovf  = ovf1_q;
				n_last = !emit2_q;
			end
			fte_pkg::OUT_E2: begin
				n_kind = 1'b1;
				n_a    = OW'(e2_lo);
				n_b    = OW'(e2_hi);
				n_ovf  = ovf2_q;
			end
			default: begin
				n_kind = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= n_kind;
			a_q    <= n_a;
			b_q    <= n_b;
			c_q    <= n_c;
			ovf_q  <= n_ovf;
			last_q <= n_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign corner_a      = a_q;
	assign corner_b      = b_q;
	assign corner_c      = c_q;
	assign edge_overflow = ovf_q;
	assign last_result   = last_q;

endmodule

`default_nettype wire

/* rtl/fte_ctrl.sv */
// Controller state machine: sequences accept, the lookups of the new and the closing edge and the result transfers.
// Depends on fte_pkg; talks to fte_datapath through cmd_t and status_t only.
`default_nettype none

module fte_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire fte_pkg::status_t status,
	output fte_pkg::cmd_t         cmd
);

	fte_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fte_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fte_pkg::S_IDLE: begin
				if (in_valid)
					state_d = fte_pkg::S_DISPATCH;
			end
			fte_pkg::S_DISPATCH: begin
				if (status.seen != 2'd0)
					state_d = fte_pkg::S_SCAN1;
				else if (status.last)
					state_d = fte_pkg::S_SCAN2;
				else
					state_d = fte_pkg::S_DONE;
			end
			fte_pkg::S_SCAN1: begin
				if (status.scan_done)
					state_d = status.last ? fte_pkg::S_SCAN2 : fte_pkg::S_EMIT_TRI;
			end
			fte_pkg::S_SCAN2: begin
				if (status.scan_done)
					state_d = fte_pkg::S_EMIT_TRI;
			end
			fte_pkg::S_EMIT_TRI: begin
				if (status.seen != 2'd2 || status.out_free)
					state_d = fte_pkg::S_EMIT_E1;
			end
			fte_pkg::S_EMIT_E1: begin
				if (!status.emit1 || status.out_free)
					state_d = fte_pkg::S_EMIT_E2;
			end
			fte_pkg::S_EMIT_E2: begin
				if (!status.emit2 || status.out_free)
					state_d = fte_pkg::S_DONE;
			end
			fte_pkg::S_DONE: begin
				state_d = fte_pkg::S_IDLE;
			end
			default: begin
				state_d = fte_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.out_sel    = fte_pkg::OUT_TRI;
		case (state_q)
			fte_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			fte_pkg::S_DISPATCH: begin
				cmd.scan_start = (status.seen != 2'd0) || status.last;
			end
			fte_pkg::S_SCAN1: begin
				cmd.scan_run = 1'b1;
				if (status.scan_done) begin
					cmd.commit     = 1'b1;
					// restart the pointer for the closing edge
					cmd.scan_start = status.last;
				end
			end
			fte_pkg::S_SCAN2: begin
				cmd.scan_run  = 1'b1;
				cmd.sel_close = 1'b1;
				cmd.commit    = status.scan_done;
			end
			fte_pkg::S_EMIT_TRI: begin
				cmd.out_sel = fte_pkg::OUT_TRI;
				cmd.load    = (status.seen == 2'd2) && status.out_free;
			end
			fte_pkg::S_EMIT_E1: begin
				cmd.out_sel = fte_pkg::OUT_E1;
				cmd.load    = status.emit1 && status.out_free;
			end
			fte_pkg::S_EMIT_E2: begin
				cmd.out_sel = fte_pkg::OUT_E2;
				cmd.load    = status.emit2 && status.out_free;
			end
			fte_pkg::S_DONE: begin
				cmd.finish = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/fan_triangulate_edge_extract.sv */
// Throughput: one corner at a time; the edge lookup scans the edge memory one entry per
// cycle over its single read port, once for the new edge and once for the closing edge.
// Reset: arst_n clears the controller, face state, fill count and output valid at once;
// the edge memory is not cleared, as only entries below the fill count are read.
`default_nettype none

module fan_triangulate_edge_extract #(
	parameter int INDEX_BITS = fte_pkg::INDEX_BITS_DEF,
	parameter int EDGE_SLOTS = fte_pkg::EDGE_SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [fte_pkg::FIELD_W-1:0] vertex_id,
	input  wire logic                        mesh_start,
	input  wire logic                        face_end,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             kind,
	output logic [fte_pkg::FIELD_W-1:0]      corner_a,
	output logic [fte_pkg::FIELD_W-1:0]      corner_b,
	output logic [fte_pkg::FIELD_W-1:0]      corner_c,
	output logic                             edge_overflow,
	output logic                             last_result
);

	fte_pkg::cmd_t    cmd;
	fte_pkg::status_t status;

	fte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	fte_datapath #(
		.INDEX_BITS (INDEX_BITS),
		.EDGE_SLOTS (EDGE_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.vertex_id     (vertex_id),
		.mesh_start    (mesh_start),
		.face_end      (face_end),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.kind          (kind),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c),
		.edge_overflow (edge_overflow),
		.last_result   (last_result)
	);

endmodule

`default_nettype wire

/* rtl/fte_checker.sv */
// Port-level checker for the fan triangulation block, bound to the top level.
// Depends on fte_pkg and the assertion macros in fan_triangulate_edge_extract_defines.svh.
`default_nettype none
`include "fan_triangulate_edge_extract_defines.svh"

module fte_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        kind,
	input wire logic [fte_pkg::FIELD_W-1:0] corner_a,
	input wire logic [fte_pkg::FIELD_W-1:0] corner_b,
	input wire logic [fte_pkg::FIELD_W-1:0] corner_c,
	input wire logic                        edge_overflow,
	input wire logic                        last_result
);

	`FTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`FTE_ASSERT_NOW(a_edge_c_zero, out_valid && kind, corner_c == '0, "edge with nonzero third corner")
	`FTE_ASSERT_NOW(a_tri_no_ovf, out_valid && !kind, !edge_overflow, "triangle flagged as overflow")
	`FTE_ASSERT_NOW(a_edge_order, out_valid && kind, corner_a <= corner_b, "edge endpoints not ordered")
	`FTE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second corner taken during work")

endmodule

bind fan_triangulate_edge_extract fte_checker u_fte_checker (.*);

`default_nettype wire

/* verif/fan_edge_checker.sv */
// Checker for the fan triangulation and edge extraction block: watches both channels,
// predicts the triangles and unique edges of every corner transfer and compares results.
// Depends on fte_pkg for the field width and the edge set size.
module fan_edge_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic                        in_ready,
	input  wire logic [fte_pkg::FIELD_W-1:0] vertex_id,
	input  wire logic                        mesh_start,
	input  wire logic                        face_end,
	input  wire logic                        out_valid,
	input  wire logic                        out_ready,
	input  wire logic                        kind,
	input  wire logic [fte_pkg::FIELD_W-1:0] corner_a,
	input  wire logic [fte_pkg::FIELD_W-1:0] corner_b,
	input  wire logic [fte_pkg::FIELD_W-1:0] corner_c,
	input  wire logic                        edge_overflow,
	input  wire logic                        last_result,
	output int                               fail_count,
	output int                               results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = fte_pkg::FIELD_W;
	localparam int SLOTS = fte_pkg::EDGE_SLOTS_DEF;
	localparam logic KIND_TRI = 1'b0;
	localparam logic KIND_EDGE = 1'b1;

	typedef struct packed {
		logic         kind;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] c;
		logic         overflow;
		logic         last;
	} fan_prim_t;

	fan_prim_t owed_prims[$];
	fan_prim_t corner_prims[$];
	fan_prim_t got_prim;
	fan_prim_t want_prim;
	logic [2*W-1:0] known_edges [SLOTS];
	int mesh_edge_count = 0;
	logic [W-1:0] face_first = '0;
	logic [W-1:0] face_prev = '0;
	int face_corners = 0;
	int bad_count = 0;

	function automatic fan_prim_t make_prim(input logic k, input logic [W-1:0] a, b, c,
			input logic ovf);
		fan_prim_t p;
		p.kind = k;
		p.a = a;
		p.b = b;
		p.c = c;
		p.overflow = ovf;
		p.last = 1'b0;
		return p;
	endfunction

	// emit an edge only on first sight in this mesh; a full set flags it and keeps nothing
	function void probe_edge(input logic [W-1:0] p, q);
		logic [W-1:0] lo;
		logic [W-1:0] hi;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		for (int i = 0; i < mesh_edge_count; i++)
			if (known_edges[i] == {lo, hi})
				return;
		if (mesh_edge_count < SLOTS) begin
			known_edges[mesh_edge_count] = {lo, hi};
			mesh_edge_count++;
			corner_prims = {corner_prims, make_prim(KIND_EDGE, lo, hi, '0, 1'b0)};
		end else begin
			corner_prims = {corner_prims, make_prim(KIND_EDGE, lo, hi, '0, 1'b1)};
		end
	endfunction

	function void predict_corner(input logic [W-1:0] v, input logic ms, fe);
		corner_prims.delete();
		if (ms) begin
			mesh_edge_count = 0;
			face_corners = 0;
		end
		if (face_corners == 0) begin
			face_first = v;
			face_prev = v;
		end
		if (face_corners >= 2)
			corner_prims = {corner_prims, make_prim(KIND_TRI, face_first, face_prev, v, 1'b0)};
		if (face_corners >= 1)
			probe_edge(face_prev, v);
		if (fe)
			probe_edge(v, face_first);
		if (corner_prims.size() > 0)
			corner_prims[corner_prims.size()-1].last = 1'b1;
		foreach (corner_prims[k])
			owed_prims = {owed_prims, corner_prims[k]};
		face_prev = v;
		if (fe)
			face_corners = 0;
		else if (face_corners < 2)
			face_corners++;
	endfunction

	function void check_field(input string name, input logic [W-1:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			bad_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_prims.delete();
			mesh_edge_count = 0;
			face_first = '0;
			face_prev = '0;
			face_corners = 0;
			fail_count <= bad_count;
			results_owed <= 0;
		end else begin
			// compare before predicting: a result can never belong to this cycle's corner
			if (out_valid && out_ready) begin
				got_prim = make_prim(kind, corner_a, corner_b, corner_c, edge_overflow);
				got_prim.last = last_result;
				if (owed_prims.size() == 0) begin
					$error("result with none pending: kind %0d a %0h b %0h c %0h", kind,
						corner_a, corner_b, corner_c);
					bad_count++;
				end else begin
					want_prim = owed_prims.pop_front();
					check_field("kind", W'(want_prim.kind), W'(got_prim.kind));
					check_field("corner_a", want_prim.a, got_prim.a);
					check_field("corner_b", want_prim.b, got_prim.b);
					check_field("corner_c", want_prim.c, got_prim.c);
					check_field("edge_overflow", W'(want_prim.overflow), W'(got_prim.overflow));
					check_field("last_result", W'(want_prim.last), W'(got_prim.last));
				end
			end
			if (in_valid && in_ready)
				predict_corner(vertex_id, mesh_start, face_end);
			fail_count <= bad_count;
			results_owed <= owed_prims.size();
		end
	end

endmodule

/* verif/testbench.sv */
// Top of the fan triangulation testbench: clock, reset, corner stimulus and output stalls.
// Depends on fte_pkg, the block fan_triangulate_edge_extract and the fan_edge_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = fte_pkg::FIELD_W;
	localparam int SLOTS = fte_pkg::EDGE_SLOTS_DEF;
	localparam int RANDOM_CORNERS = 195;
	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 40;
	localparam logic [W-1:0] TOP_INDEX = {W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [W-1:0] vertex_id = '0;
	logic mesh_start = 1'b0;
	logic face_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [W-1:0] corner_a;
	logic [W-1:0] corner_b;
	logic [W-1:0] corner_c;
	logic edge_overflow;
	logic last_result;
	int fail_count;
	int results_owed;
	int cycles = 0;
	int corners_sent = 0;
	int calm_left = 0;

	always #6 clk = ~clk;

	fan_triangulate_edge_extract dut (.*);

	fan_edge_checker monitor (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// mostly back to back, often a short gap, now and then a long pause
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [W-1:0] pick_vertex();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return TOP_INDEX;
		return W'($urandom);
	endfunction

	task automatic put_corner(input logic [W-1:0] v, input logic ms, fe);
		int gap;
		vertex_id <= v;
		mesh_start <= ms;
		face_end <= fe;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		corners_sent++;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			gap = idle_len();
			if ($urandom_range(0, 29) == 0)
				calm_left = $urandom_range(15, 60);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int hold;
		int gap;
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				hold = $urandom_range(40, 150);
			else
				hold = $urandom_range(1, 6);
			repeat (hold) @(posedge clk);
			gap = idle_len();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		logic [W-1:0] pool [8];
		logic [W-1:0] v;
		int faces;
		int face_size;
		int r;
		int random_from;
		bit clear_mesh;
		bit first_mesh;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// straight after reset, no mesh start: the set is empty already
		put_corner('0, 1'b0, 1'b0);
		put_corner(TOP_INDEX, 1'b0, 1'b0);
		put_corner(W'(5), 1'b0, 1'b1);
		// single-corner face, then the same self edge again
		put_corner(W'(7), 1'b1, 1'b1);
		put_corner(W'(7), 1'b0, 1'b1);
		// two-corner faces: closing edge duplicates the open one; then a four-corner face
		put_corner(W'(3), 1'b0, 1'b0);
		put_corner(W'(9), 1'b0, 1'b1);
		put_corner(W'(9), 1'b0, 1'b0);
		put_corner(W'(3), 1'b0, 1'b1);
		put_corner(W'(10), 1'b0, 1'b0);
		put_corner(W'(11), 1'b0, 1'b0);
		put_corner(W'(12), 1'b0, 1'b0);
		put_corner(W'(13), 1'b0, 1'b1);
		// drop an unfinished face on mesh start
		put_corner(W'(20), 1'b0, 1'b0);
		put_corner(W'(21), 1'b0, 1'b0);
		put_corner(W'(22), 1'b1, 1'b0);
		put_corner(W'(23), 1'b0, 1'b0);
		put_corner(W'(24), 1'b0, 1'b1);
		// open face with alternating bit patterns
		put_corner(W'(24'hAAAAAA), 1'b0, 1'b0);
		put_corner(W'(24'h555555), 1'b0, 1'b0);
		put_corner(W'(24'h800000), 1'b0, 1'b0);
		put_corner(W'(24'h7FFFFF), 1'b0, 1'b0);
		put_corner(W'(1), 1'b0, 1'b0);
		put_corner(W'(24'h555555), 1'b1, 1'b1);
		// an edge seen in an earlier mesh comes out again
		put_corner(W'(3), 1'b1, 1'b0);
		put_corner(W'(9), 1'b0, 1'b1);

		// random meshes drawn from a small vertex pool so edges repeat
		random_from = corners_sent;
		first_mesh = 1'b1;
		while (corners_sent - random_from < RANDOM_CORNERS) begin
			clear_mesh = first_mesh || ($urandom_range(0, 9) != 0);
			first_mesh = 1'b0;
			foreach (pool[k])
				pool[k] = pick_vertex();
			faces = $urandom_range(1, 6);
			for (int f = 0; f < faces; f++) begin
				r = $urandom_range(0, 19);
				if (r < 2)
					face_size = 1;
				else if (r < 4)
					face_size = 2;
				else if (r < 12)
					face_size = 3;
				else if (r < 18)
					face_size = $urandom_range(4, 6);
				else
					face_size = $urandom_range(7, 12);
				for (int c = 0; c < face_size; c++) begin
					if ($urandom_range(0, 4) == 0)
						v = pick_vertex();
					else
						v = pool[$urandom_range(0, 7)];
					put_corner(v,
						(f == 0 && c == 0 && clear_mesh) || ($urandom_range(0, 39) == 0),
						(c == face_size - 1) && ($urandom_range(0, 11) != 0));
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		// hold on for a full scan in case a stray result follows
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
